[hw/rtl/prrs_pkg.sv]
// Package for the priority round-robin thread scheduler.
// Beat types and operation / status codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prrs_pkg;

  localparam int TID_W    = 5;
  localparam int PRIO_W   = 4;
  localparam int STATUS_W = 2;
  localparam int FUNC_W   = 2;
  localparam int LEVELS_W = 16;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_SET   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SCHED = 2'd1;
  localparam logic [FUNC_W-1:0] FN_EXIT  = 2'd2;

  // Thread status codes; bit 1 set means the thread sits on a run queue
  localparam logic [STATUS_W-1:0] ST_STOPPED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PENDING = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RUNNING = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [TID_W-1:0]    thread_id;
    logic [PRIO_W-1:0]   priority_req;
    logic [STATUS_W-1:0] new_status;
  } prrs_in_t;

  typedef struct packed {
    logic [TID_W-1:0]    chosen_thread;
    logic                chosen_valid;
    logic [LEVELS_W-1:0] ready_levels;
  } prrs_out_t;

endpackage

`default_nettype wire

[hw/rtl/priority_round_robin_scheduler.sv]
// Priority round-robin thread scheduler, top level.
// Uses prrs_pkg for beat types and codes.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+-----------------------
//   in      | in  | in_valid_i / in_stall_o   | in_data_i  (prrs_in_t)
//   out     | out | out_valid_o / out_stall_i | out_data_o (prrs_out_t)
//
// One beat at a time: after accept a beat walks the sequencer steps from S_DECODE on, then
// S_OUT loads the output register and the sequencer returns to S_IDLE for the next beat.
// A status change that appends to a non-empty queue is the longest, since the link memories
// take one write each per cycle. A finished result waits in the output register while the
// next beat is taken; that beat holds in its last step while the register is still stalled.
// Reset clears thread status, level bitmap and current thread; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module priority_round_robin_scheduler
  import prrs_pkg::*;
#(
  parameter int THREAD_COUNT = 32,
  parameter int LEVEL_COUNT  = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire prrs_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output prrs_out_t      out_data_o
);

  localparam int TW    = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int LW    = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int TEXTW = 9;
  localparam int LEXTW = 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UL_LINK,
    S_UL_HEAD,
    S_AP_HEAD,
    S_AP_TAIL,
    S_AP_W1,
    S_AP_W2,
    S_SCH_HEAD,
    S_SCH_ROT,
    S_OUT
  } fsm_e;

  fsm_e                   fsm_q;
  logic [FUNC_W-1:0]      func_q;
  logic [STATUS_W-1:0]    st_q;
  logic [LW-1:0]          lvl_q;
  logic                   tid_ok_q;
  logic [TW-1:0]          t_q;
  logic [TW-1:0]          n_q;
  logic [TW-1:0]          h_q;
  logic [LW-1:0]          al_q;
  logic [LEVEL_COUNT-1:0] mask_q;
  logic [TW-1:0]          cur_q;
  logic                   cur_vld_q;
  prrs_out_t              out_q;
  logic                   out_vld_q;

  // thread status needs a reset value, so it lives in flops with one read port
  logic [STATUS_W-1:0]    thr_st_q [THREAD_COUNT];

  logic [LW-1:0]          lvl_mem  [THREAD_COUNT];
  logic [TW-1:0]          nx_mem   [THREAD_COUNT];
  logic [TW-1:0]          pv_mem   [THREAD_COUNT];
  logic [TW-1:0]          hd_mem   [LEVEL_COUNT];

  logic [LW-1:0]          lv_rd_q;
  logic [TW-1:0]          nx_rd_q;
  logic [TW-1:0]          pv_rd_q;
  logic [TW-1:0]          hd_rd_q;

  logic [TW-1:0]          nx_ra, pv_ra;
  logic [LW-1:0]          hd_ra;
  logic                   nx_we, pv_we, hd_we, lv_we, st_we;
  logic [TW-1:0]          nx_wa, nx_wd, pv_wa, pv_wd, hd_wd, st_wa;
  logic [LW-1:0]          hd_wa;
  logic [STATUS_W-1:0]    st_wd;

  logic                   in_acc;
  logic [TEXTW-1:0]       tid_ext;
  logic [TEXTW-1:0]       cur_ext;
  logic [LEXTW-1:0]       prio_ext;
  logic [LEXTW-1:0]       prio_sat;
  logic [31:0]            mask_ext;
  logic [LW-1:0]          ffs;
  logic                   was_on;
  logic                   now_on;

  assign in_acc     = in_valid_i && (fsm_q == S_IDLE);
  assign in_stall_o = (fsm_q != S_IDLE);

  always_comb begin
    tid_ext  = TEXTW'(in_data_i.thread_id);
    cur_ext  = TEXTW'(cur_q);
    prio_ext = LEXTW'(in_data_i.priority_req);
    prio_sat = (prio_ext >= LEXTW'(LEVEL_COUNT)) ? LEXTW'(LEVEL_COUNT - 1) : prio_ext;
    mask_ext = 32'(mask_q);
    was_on   = thr_st_q[t_q][1];
    now_on   = st_q[1];
  end

  // lowest-numbered non-empty level
  always_comb begin
    ffs = '0;
    for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        ffs = LW'(i);
      end
    end
  end

  // memory ports per sequencer step
  always_comb begin
    nx_ra = t_q;
    pv_ra = t_q;
    hd_ra = al_q;
    nx_we = 1'b0;
    nx_wa = t_q;
    nx_wd = t_q;
    pv_we = 1'b0;
    pv_wa = t_q;
    pv_wd = t_q;
    hd_we = 1'b0;
    hd_wa = al_q;
    hd_wd = t_q;
    lv_we = 1'b0;
    st_we = 1'b0;
    st_wa = t_q;
    st_wd = st_q;
    case (fsm_q)
      S_DECODE: begin
        hd_ra = ffs;
        case (func_q)
          FN_SET: begin
            if (tid_ok_q) begin
              st_we = 1'b1;
              // level of a thread that stays queued is kept
              lv_we = !(was_on && now_on);
            end
          end
          FN_SCHED: begin
            if (cur_vld_q && (thr_st_q[t_q] == ST_RUNNING)) begin
              st_we = 1'b1;
              st_wd = ST_PENDING;
            end
          end
          FN_EXIT: begin
            if (cur_vld_q) begin
              st_we = 1'b1;
              st_wd = ST_STOPPED;
            end
          end
          default: ;
        endcase
      end
      S_UL_LINK: begin
        hd_ra = lv_rd_q;
        if (nx_rd_q != t_q) begin
          nx_we = 1'b1;
          nx_wa = pv_rd_q;
          nx_wd = nx_rd_q;
          pv_we = 1'b1;
          pv_wa = nx_rd_q;
          pv_wd = pv_rd_q;
        end
      end
      S_UL_HEAD: begin
        if (hd_rd_q == t_q) begin
          hd_we = 1'b1;
          hd_wd = n_q;
        end
      end
      S_AP_HEAD: begin
        // empty level: the thread forms a one-entry ring
        if (!mask_q[al_q]) begin
          hd_we = 1'b1;
          nx_we = 1'b1;
          pv_we = 1'b1;
        end
      end
      S_AP_TAIL: begin
        pv_ra = hd_rd_q;
      end
      S_AP_W1: begin
        nx_we = 1'b1;
        nx_wa = pv_rd_q;
        pv_we = 1'b1;
        pv_wd = pv_rd_q;
      end
      S_AP_W2: begin
        nx_we = 1'b1;
        nx_wd = h_q;
        pv_we = 1'b1;
        pv_wa = h_q;
      end
      S_SCH_HEAD: begin
        nx_ra = hd_rd_q;
      end
      S_SCH_ROT: begin
        hd_we = 1'b1;
        hd_wd = nx_rd_q;
        st_we = 1'b1;
        st_wa = h_q;
        st_wd = ST_RUNNING;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < THREAD_COUNT; i++) begin
        thr_st_q[i] <= ST_STOPPED;
      end
    end else if (st_we) begin
      thr_st_q[st_wa] <= st_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lv_we) begin
      lvl_mem[t_q] <= lvl_q;
    end
    lv_rd_q <= lvl_mem[t_q];
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      nx_mem[nx_wa] <= nx_wd;
    end
    nx_rd_q <= nx_mem[nx_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) begin
      pv_mem[pv_wa] <= pv_wd;
    end
    pv_rd_q <= pv_mem[pv_ra];
  end

  always_ff @(posedge clk_i) begin
    if (hd_we) begin
      hd_mem[hd_wa] <= hd_wd;
    end
    hd_rd_q <= hd_mem[hd_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q     <= S_IDLE;
      func_q    <= FN_SET;
      st_q      <= ST_STOPPED;
      lvl_q     <= '0;
      tid_ok_q  <= 1'b0;
      t_q       <= '0;
      n_q       <= '0;
      h_q       <= '0;
      al_q      <= '0;
      mask_q    <= '0;
      cur_q     <= '0;
      cur_vld_q <= 1'b0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if ((fsm_q == S_OUT) && (!out_vld_q || !out_stall_i)) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (fsm_q)
        S_IDLE: begin
          if (in_acc) begin
            func_q   <= in_data_i.func;
            st_q     <= in_data_i.new_status;
            lvl_q    <= prio_sat[LW-1:0];
            tid_ok_q <= (tid_ext < TEXTW'(THREAD_COUNT));
            t_q      <= (in_data_i.func == FN_SET) ? tid_ext[TW-1:0] : cur_q;
            fsm_q    <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (func_q)
            FN_SET: begin
              if (!tid_ok_q) begin
                fsm_q <= S_OUT;
              end else if (was_on && !now_on) begin
                fsm_q <= S_UL_LINK;
              end else if (!was_on && now_on) begin
                al_q  <= lvl_q;
                fsm_q <= S_AP_HEAD;
              end else begin
                fsm_q <= S_OUT;
              end
            end
            FN_SCHED: begin
              if (mask_q == '0) begin
                cur_vld_q <= 1'b0;
                cur_q     <= '0;
                fsm_q     <= S_OUT;
              end else begin
                al_q  <= ffs;
                fsm_q <= S_SCH_HEAD;
              end
            end
            FN_EXIT: begin
              if (cur_vld_q) begin
                cur_vld_q <= 1'b0;
                cur_q     <= '0;
                fsm_q     <= was_on ? S_UL_LINK : S_OUT;
              end else begin
                fsm_q <= S_OUT;
              end
            end
            default: fsm_q <= S_OUT;
          endcase
        end
        S_UL_LINK: begin
          if (nx_rd_q == t_q) begin
            mask_q[lv_rd_q] <= 1'b0;
            fsm_q           <= S_OUT;
          end else begin
            n_q   <= nx_rd_q;
            al_q  <= lv_rd_q;
            fsm_q <= S_UL_HEAD;
          end
        end
        S_UL_HEAD: fsm_q <= S_OUT;
        S_AP_HEAD: begin
          if (!mask_q[al_q]) begin
            mask_q[al_q] <= 1'b1;
            fsm_q        <= S_OUT;
          end else begin
            fsm_q <= S_AP_TAIL;
          end
        end
        S_AP_TAIL: begin
          h_q   <= hd_rd_q;
          fsm_q <= S_AP_W1;
        end
        S_AP_W1: fsm_q <= S_AP_W2;
        S_AP_W2: fsm_q <= S_OUT;
        S_SCH_HEAD: begin
          h_q   <= hd_rd_q;
          fsm_q <= S_SCH_ROT;
        end
        S_SCH_ROT: begin
          cur_q     <= h_q;
          cur_vld_q <= 1'b1;
          fsm_q     <= S_OUT;
        end
        S_OUT: begin
          if (!out_vld_q || !out_stall_i) begin
            out_q.chosen_thread <= cur_ext[TID_W-1:0];
            out_q.chosen_valid  <= cur_vld_q;
            out_q.ready_levels  <= mask_ext[LEVELS_W-1:0];
            fsm_q               <= S_IDLE;
          end
        end
        default: fsm_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[hw/rtl/prrs_checker.sv]
// Port-level checks for the priority round-robin scheduler.
// Uses prrs_pkg; bound to priority_round_robin_scheduler below.
`timescale 1ns / 1ps
`default_nettype none

module prrs_checker
  import prrs_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire prrs_in_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire prrs_out_t out_data_o
);

  // a held result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
  else $error("stalled result beat changed");

  // one beat at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
  else $error("input taken while a beat is in progress");

  // a new result only shows after the sequencer worked on a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
  else $error("result beat without a beat in progress");

  // no current thread reports thread zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.chosen_valid |-> out_data_o.chosen_thread == '0)
  else $error("thread reported without a current thread");

endmodule

bind priority_round_robin_scheduler prrs_checker u_prrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[tb/priority_round_robin_scheduler_test.sv]
// Self-checking test for the priority round-robin thread scheduler.
// Holds a run-queue scoreboard class and the stimulus tasks; needs prrs_pkg and the top level.
`timescale 1ns / 1ps

module priority_round_robin_scheduler_test;
  import prrs_pkg::*;

  localparam int THREADS     = 32;
  localparam int LEVELS      = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 257;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  // Tracks run queues, level bitmap and current thread; queues the expected grants.
  class run_queue_scoreboard;
    logic [STATUS_W-1:0] thr_status [THREADS];
    logic [PRIO_W-1:0]   thr_level  [THREADS];
    logic [TID_W-1:0]    link_next  [THREADS];
    logic [TID_W-1:0]    link_prev  [THREADS];
    logic [TID_W-1:0]    level_head [LEVELS];
    logic [LEVELS-1:0]   ready_mask;
    logic [TID_W-1:0]    cur_thread;
    logic                cur_valid;
    prrs_out_t           pending_grants[$];
    int unsigned         mismatches;

    function new();
      foreach (thr_status[i]) begin
        thr_status[i] = ST_STOPPED;
        thr_level[i]  = '0;
        link_next[i]  = '0;
        link_prev[i]  = '0;
      end
      foreach (level_head[i]) level_head[i] = '0;
      ready_mask = '0;
      cur_thread = '0;
      cur_valid  = 1'b0;
      mismatches = 0;
    endfunction

    function void enqueue_thread(logic [TID_W-1:0] t, logic [PRIO_W-1:0] lvl);
      logic [TID_W-1:0] head;
      logic [TID_W-1:0] tail;
      if (!ready_mask[lvl]) begin
        level_head[lvl] = t;
        link_next[t]    = t;
        link_prev[t]    = t;
        ready_mask[lvl] = 1'b1;
      end else begin
        head = level_head[lvl];
        tail = link_prev[head];
        link_next[tail] = t;
        link_prev[t]    = tail;
        link_next[t]    = head;
        link_prev[head] = t;
      end
    endfunction

    function void dequeue_thread(logic [TID_W-1:0] t, logic [PRIO_W-1:0] lvl);
      logic [TID_W-1:0] n;
      logic [TID_W-1:0] p;
      n = link_next[t];
      p = link_prev[t];
      if (n == t) begin
        ready_mask[lvl] = 1'b0;
      end else begin
        link_next[p] = n;
        link_prev[n] = p;
        if (level_head[lvl] == t) level_head[lvl] = n;
      end
    endfunction

    // A queued thread keeps its level; a new level only lands while it is off the queue.
    function void change_status(logic [TID_W-1:0] t, logic [STATUS_W-1:0] st,
                                logic [PRIO_W-1:0] lvl, bit store_level);
      bit was_on;
      bit now_on;
      was_on = thr_status[t][1];
      now_on = st[1];
      if (was_on && !now_on) dequeue_thread(t, thr_level[t]);
      if ((!now_on || !was_on) && store_level) thr_level[t] = lvl;
      if (now_on && !was_on) enqueue_thread(t, thr_level[t]);
      thr_status[t] = st;
    endfunction

    function void note_request(prrs_in_t req);
      prrs_out_t grant;
      int lvl;
      case (req.func)
        FN_SET: change_status(req.thread_id, req.new_status, req.priority_req, 1'b1);
        FN_SCHED: begin
          if (cur_valid && thr_status[cur_thread] == ST_RUNNING)
            thr_status[cur_thread] = ST_PENDING;
          if (ready_mask == '0) begin
            cur_valid  = 1'b0;
            cur_thread = '0;
          end else begin
            lvl = 0;
            while (lvl < LEVELS - 1 && !ready_mask[lvl]) lvl++;
            cur_thread             = level_head[lvl];
            level_head[lvl]        = link_next[cur_thread];
            thr_status[cur_thread] = ST_RUNNING;
            cur_valid              = 1'b1;
          end
        end
        FN_EXIT: begin
          if (cur_valid) begin
            change_status(cur_thread, ST_STOPPED, '0, 1'b0);
            cur_valid  = 1'b0;
            cur_thread = '0;
          end
        end
        default: ;
      endcase
      grant.chosen_thread = cur_thread;
      grant.chosen_valid  = cur_valid;
      grant.ready_levels  = ready_mask;
      pending_grants.push_back(grant);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endfunction

    function void check_grant(prrs_out_t got);
      prrs_out_t want;
      if (pending_grants.size() == 0) begin
        flag("beat with nothing outstanding", '0, 32'(got));
        return;
      end
      want = pending_grants.pop_front();
      if (got.chosen_thread !== want.chosen_thread)
        flag("chosen_thread", 32'(want.chosen_thread), 32'(got.chosen_thread));
      if (got.chosen_valid !== want.chosen_valid)
        flag("chosen_valid", 32'(want.chosen_valid), 32'(got.chosen_valid));
      if (got.ready_levels !== want.ready_levels)
        flag("ready_levels", 32'(want.ready_levels), 32'(got.ready_levels));
    endfunction

    function int outstanding();
      return pending_grants.size();
    endfunction

    function bit clean();
      return mismatches == 0 && pending_grants.size() == 0;
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  prrs_in_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  prrs_out_t out_data_o;

  run_queue_scoreboard sb;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  always #2 clk_i = ~clk_i;

  priority_round_robin_scheduler #(
    .THREAD_COUNT(THREADS),
    .LEVEL_COUNT (LEVELS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Result side: check accepted beats, then pick next cycle's stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_grant(out_data_o);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  function automatic prrs_in_t make_req(logic [FUNC_W-1:0] f, logic [TID_W-1:0] t,
                                        logic [PRIO_W-1:0] p, logic [STATUS_W-1:0] s);
    prrs_in_t r;
    r.func         = f;
    r.thread_id    = t;
    r.priority_req = p;
    r.new_status   = s;
    return r;
  endfunction

  // Mostly status changes and picks on a crowded set of low levels, some exits and noise.
  function automatic prrs_in_t random_req();
    prrs_in_t r;
    int unsigned roll;
    r.thread_id    = ($urandom_range(99) < 60) ? TID_W'($urandom_range(7))
                                               : TID_W'($urandom_range(31));
    r.priority_req = ($urandom_range(99) < 60) ? PRIO_W'($urandom_range(3))
                                               : PRIO_W'($urandom_range(15));
    r.new_status   = ($urandom_range(99) < 60) ? STATUS_W'($urandom_range(3, 2))
                                               : STATUS_W'($urandom_range(3));
    roll = $urandom_range(99);
    if (roll < 55)      r.func = FN_SET;
    else if (roll < 85) r.func = FN_SCHED;
    else if (roll < 95) r.func = FN_EXIT;
    else                r.func = FN_UNUSED;
    return r;
  endfunction

  task automatic send_request(input prrs_in_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    prrs_in_t directed[$];
    int unsigned idle_mix[4];
    int unsigned stall_mix[4];

    sb = new();
    idle_mix  = '{0, 85, 0, 32};
    stall_mix = '{0, 0, 85, 32};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(make_req(FN_SCHED,  5'd0,  4'd0,  ST_STOPPED)); // nothing ready
    directed.push_back(make_req(FN_EXIT,   5'd0,  4'd0,  ST_STOPPED)); // no current thread
    directed.push_back(make_req(FN_UNUSED, 5'd9,  4'd3,  ST_PENDING));
    directed.push_back(make_req(FN_SET,    5'd31, 4'd15, ST_PENDING));
    directed.push_back(make_req(FN_SET,    5'd0,  4'd0,  ST_RUNNING));
    directed.push_back(make_req(FN_SET,    5'd5,  4'd15, ST_PENDING));
    directed.push_back(make_req(FN_SCHED,  5'd0,  4'd0,  ST_STOPPED));
    directed.push_back(make_req(FN_SCHED,  5'd0,  4'd0,  ST_STOPPED)); // same thread again
    directed.push_back(make_req(FN_SET,    5'd0,  4'd7,  ST_BLOCKED)); // current gets blocked
    directed.push_back(make_req(FN_SCHED,  5'd0,  4'd0,  ST_STOPPED));
    directed.push_back(make_req(FN_SET,    5'd31, 4'd3,  ST_RUNNING)); // level kept while queued
    directed.push_back(make_req(FN_SCHED,  5'd0,  4'd0,  ST_STOPPED));
    directed.push_back(make_req(FN_SCHED,  5'd0,  4'd0,  ST_STOPPED));
    directed.push_back(make_req(FN_SET,    5'd0,  4'd7,  ST_PENDING));
    directed.push_back(make_req(FN_SCHED,  5'd0,  4'd0,  ST_STOPPED));
    directed.push_back(make_req(FN_EXIT,   5'd0,  4'd0,  ST_STOPPED));
    directed.push_back(make_req(FN_EXIT,   5'd31, 4'd15, ST_RUNNING));
    directed.push_back(make_req(FN_SET,    5'd31, 4'd0,  ST_STOPPED));
    directed.push_back(make_req(FN_SET,    5'd5,  4'd9,  ST_BLOCKED));
    directed.push_back(make_req(FN_SCHED,  5'd0,  4'd0,  ST_STOPPED));
    directed.push_back(make_req(FN_SET,    5'd12, 4'd15, ST_RUNNING));
    directed.push_back(make_req(FN_SCHED,  5'd0,  4'd0,  ST_STOPPED));
    directed.push_back(make_req(FN_EXIT,   5'd0,  4'd0,  ST_STOPPED));
    directed.push_back(make_req(FN_UNUSED, 5'd31, 4'd15, ST_RUNNING));
    foreach (directed[i]) send_request(directed[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_mix[ph];
      recv_stall_pct = stall_mix[ph];
      // long result-side hold while beats keep coming, so the input backs up
      if (ph == 0) hold_request = 1'b1;
      repeat (PHASE_ITEMS) send_request(random_req());
      drain();
    end

    recv_stall_pct = 0;
    repeat (20) @(posedge clk_i);
    if (sb.clean()) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
